// ===== design/fhd_pkg.sv =====
// fhd_pkg: shared types, codes and constants of the frame header deframer.
// No dependencies; used by every module of the block.
package fhd_pkg;

    localparam int unsigned HDR_BYTES   = 16;
    localparam int unsigned HDR_CNT_W   = $clog2(HDR_BYTES);
    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_LEN = 2'd0;
    localparam logic [1:0] CFG_MAGIC   = 2'd1;
    localparam logic [1:0] CFG_VERSION = 2'd2;

    localparam logic [31:0] MAX_LEN_RESET = 32'd65536;
    localparam logic [31:0] MAGIC_RESET   = 32'd0;
    localparam logic [7:0]  VERSION_RESET = 8'd0;

    // input operations
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC   = 2'd1;
    localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;
    localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd3;

    typedef struct packed {
        logic [31:0] max_len;
        logic [31:0] magic;
        logic [7:0]  version;
    } cfg_t;

    // what the back end must build for one queued request
    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_EMPTY,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  status;
        logic [7:0]  opcode;
        logic [15:0] flags;
        logic [31:0] req_id;
        logic [31:0] length;
        logic [7:0]  data;
        logic        first;
        logic        last;
    } req_t;

endpackage

// ===== design/fhd_front.sv =====
// fhd_front: accepts stream requests, collects the header, checks it and
// classifies each byte, queueing any result request. Depends on fhd_pkg.
module fhd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  fhd_pkg::cfg_t    cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_operation,
    input  logic [7:0]       s_stream_byte,
    output logic             push_valid,
    input  logic             push_ready,
    output fhd_pkg::req_t    push_req
);

    localparam int unsigned CW = fhd_pkg::HDR_CNT_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(fhd_pkg::HDR_BYTES - 1);

    // header bytes 0..14; byte 15 is taken straight from the input
    logic [7:0]    hdr_reg [fhd_pkg::HDR_BYTES-1];
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   remain_reg, remain_next;
    logic          in_payload_reg, in_payload_next;
    logic          halted_reg, halted_next;

    logic [7:0]  opcode_reg;
    logic [15:0] flags_reg;
    logic [31:0] id_reg, len_reg;

    logic        accept;
    logic        hdr_wr;
    logic        capture;
    logic [31:0] magic_w, id_w, len_w;
    logic [15:0] flags_w;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    assign magic_w = {hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3]};
    assign flags_w = {hdr_reg[6], hdr_reg[7]};
    assign id_w    = {hdr_reg[8], hdr_reg[9], hdr_reg[10], hdr_reg[11]};
    assign len_w   = {hdr_reg[12], hdr_reg[13], hdr_reg[14], s_stream_byte};

    always_comb begin
        count_next      = count_reg;
        remain_next     = remain_reg;
        in_payload_next = in_payload_reg;
        halted_next     = halted_reg;
        hdr_wr          = 1'b0;
        capture         = 1'b0;
        push_valid      = 1'b0;
        push_req        = '0;
        push_req.kind   = fhd_pkg::KIND_ERROR;

        if (accept) begin
            if (s_operation == fhd_pkg::OP_CLEAR) begin
                count_next      = '0;
                remain_next     = '0;
                in_payload_next = 1'b0;
                halted_next     = 1'b0;
            end else if (halted_reg) begin
                push_valid      = 1'b1;
                push_req.status = fhd_pkg::STATUS_BAD_LENGTH;
            end else if (in_payload_reg) begin
                push_valid      = 1'b1;
                push_req.kind   = fhd_pkg::KIND_PAYLOAD;
                push_req.status = fhd_pkg::STATUS_OK;
                push_req.opcode = opcode_reg;
                push_req.flags  = flags_reg;
                push_req.req_id = id_reg;
                push_req.length = len_reg;
                push_req.data   = s_stream_byte;
                push_req.first  = (remain_reg == len_reg);
                push_req.last   = (remain_reg == 32'd1);
                remain_next     = remain_reg - 32'd1;
                if (remain_reg == 32'd1) begin
                    in_payload_next = 1'b0;
                    count_next      = '0;
                end
            end else if (count_reg != LAST_IDX) begin
                hdr_wr     = 1'b1;
                count_next = count_reg + CW'(1);
            end else begin
                // 16th header byte: magic, then version, then length
                count_next = '0;
                push_valid = 1'b1;
                if (magic_w != cfg.magic) begin
                    push_req.status = fhd_pkg::STATUS_BAD_MAGIC;
                    halted_next     = 1'b1;
                end else if (hdr_reg[4] != cfg.version) begin
                    push_req.status = fhd_pkg::STATUS_BAD_VERSION;
                    halted_next     = 1'b1;
                end else if (len_w > cfg.max_len) begin
                    push_req.status = fhd_pkg::STATUS_BAD_LENGTH;
                    halted_next     = 1'b1;
                end else if (len_w == 32'd0) begin
                    push_req.kind   = fhd_pkg::KIND_EMPTY;
                    push_req.status = fhd_pkg::STATUS_OK;
                    push_req.opcode = hdr_reg[5];
                    push_req.flags  = flags_w;
                    push_req.req_id = id_w;
                    push_req.first  = 1'b1;
                    push_req.last   = 1'b1;
                end else begin
                    push_valid      = 1'b0;
                    capture         = 1'b1;
                    in_payload_next = 1'b1;
                    remain_next     = len_w;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            remain_reg     <= '0;
            in_payload_reg <= 1'b0;
            halted_reg     <= 1'b0;
        end else begin
            count_reg      <= count_next;
            remain_reg     <= remain_next;
            in_payload_reg <= in_payload_next;
            halted_reg     <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hdr_wr) begin
            hdr_reg[count_reg] <= s_stream_byte;
        end
        if (capture) begin
            opcode_reg <= hdr_reg[5];
            flags_reg  <= flags_w;
            id_reg     <= id_w;
            len_reg    <= len_w;
        end
    end

endmodule

// ===== design/fhd_queue.sv =====
// fhd_queue: small FIFO of result requests between front and back end.
// Depends on fhd_pkg for the request type.
module fhd_queue #(
    parameter int unsigned DEPTH = fhd_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  fhd_pkg::req_t wr_req,
    output logic          rd_valid,
    input  logic          rd_ready,
    output fhd_pkg::req_t rd_req
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] NUM_FULL = NW'(DEPTH);

    fhd_pkg::req_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] num_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (num_reg != NUM_FULL);
    assign rd_valid = (num_reg != '0);
    assign rd_req   = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            num_reg    <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd) begin
                num_reg <= num_reg + NW'(1);
            end else if (do_rd && !do_wr) begin
                num_reg <= num_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_req;
        end
    end

endmodule

// ===== design/fhd_back.sv =====
// fhd_back: builds result fields from a queued request into the output
// register. Depends on fhd_pkg.
module fhd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  fhd_pkg::req_t req,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_status,
    output logic [7:0]    m_opcode,
    output logic [15:0]   m_frame_flags,
    output logic [31:0]   m_req_id,
    output logic [31:0]   m_payload_length,
    output logic [7:0]    m_payload_byte,
    output logic          m_has_byte,
    output logic          m_frame_first,
    output logic          m_frame_last
);

    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [7:0]  opcode_reg, byte_reg;
    logic [15:0] flags_reg;
    logic [31:0] id_reg, len_reg;
    logic        has_byte_reg, first_reg, last_reg;
    logic        load;

    assign req_ready = !valid_reg || m_ready;
    assign load      = req_valid && req_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (req_ready) begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= req.status;
            case (req.kind)
                fhd_pkg::KIND_PAYLOAD: begin
                    opcode_reg   <= req.opcode;
                    flags_reg    <= req.flags;
                    id_reg       <= req.req_id;
                    len_reg      <= req.length;
                    byte_reg     <= req.data;
                    has_byte_reg <= 1'b1;
                    first_reg    <= req.first;
                    last_reg     <= req.last;
                end
                fhd_pkg::KIND_EMPTY: begin
                    opcode_reg   <= req.opcode;
                    flags_reg    <= req.flags;
                    id_reg       <= req.req_id;
                    len_reg      <= 32'd0;
                    byte_reg     <= 8'd0;
                    has_byte_reg <= 1'b0;
                    first_reg    <= 1'b1;
                    last_reg     <= 1'b1;
                end
                default: begin
                    // errors carry the status only
                    opcode_reg   <= 8'd0;
                    flags_reg    <= 16'd0;
                    id_reg       <= 32'd0;
                    len_reg      <= 32'd0;
                    byte_reg     <= 8'd0;
                    has_byte_reg <= 1'b0;
                    first_reg    <= 1'b0;
                    last_reg     <= 1'b0;
                end
            endcase
        end
    end

    assign m_valid          = valid_reg;
    assign m_status         = status_reg;
    assign m_opcode         = opcode_reg;
    assign m_frame_flags    = flags_reg;
    assign m_req_id         = id_reg;
    assign m_payload_length = len_reg;
    assign m_payload_byte   = byte_reg;
    assign m_has_byte       = has_byte_reg;
    assign m_frame_first    = first_reg;
    assign m_frame_last     = last_reg;

endmodule

// ===== design/frame_header_deframer.sv =====
// frame_header_deframer: top level of the length-prefixed frame deframer.
// Depends on fhd_pkg, fhd_front, fhd_queue and fhd_back.
//
// Takes one stream byte per request and gathers a 16-byte big-endian header
// (magic, version, opcode, flags, request id, payload length). On the last
// header byte the magic, version and length limit are checked in that order;
// the first failure returns one error result and halts the block, after which
// every byte returns status 3 until a clear request (operation 1), which also
// drops any partial header or frame and returns nothing. Each payload byte of
// a good frame returns one result tagged with the header fields and first/last
// marks; a zero-length frame returns one result without a byte. Throughput is
// one request per clock while s_ready is high: the front end classifies a
// byte combinationally, a request FIFO (QUEUE_DEPTH entries) decouples it from
// the back end, which formats one result per cycle into the output register
// while m_ready allows. A result passes through the FIFO and then the output
// register before it leaves. With m_ready low, the output register plus the
// FIFO hold QUEUE_DEPTH+1 results; once the FIFO is full s_ready drops and
// every request waits, header bytes and clears included. Configuration
// registers are written through cfg_wr_en/cfg_addr/cfg_wr_data, take effect
// at the next header check, and unknown indexes are ignored.
module frame_header_deframer #(
    parameter int unsigned QUEUE_DEPTH = fhd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data,
    // stream input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_stream_byte,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_opcode,
    output logic [15:0] m_frame_flags,
    output logic [31:0] m_req_id,
    output logic [31:0] m_payload_length,
    output logic [7:0]  m_payload_byte,
    output logic        m_has_byte,
    output logic        m_frame_first,
    output logic        m_frame_last
);

    fhd_pkg::cfg_t cfg_reg;

    logic          push_valid, push_ready;
    fhd_pkg::req_t push_req;
    logic          pop_valid, pop_ready;
    fhd_pkg::req_t pop_req;

    // configuration registers; indexes past the list fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_len <= fhd_pkg::MAX_LEN_RESET;
            cfg_reg.magic   <= fhd_pkg::MAGIC_RESET;
            cfg_reg.version <= fhd_pkg::VERSION_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fhd_pkg::CFG_MAX_LEN: cfg_reg.max_len <= cfg_wr_data;
                fhd_pkg::CFG_MAGIC:   cfg_reg.magic   <= cfg_wr_data;
                fhd_pkg::CFG_VERSION: cfg_reg.version <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // front end: header collection, checks and classification
    fhd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_stream_byte (s_stream_byte),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_req      (push_req)
    );

    // request FIFO between the two halves
    fhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_req   (push_req),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_req   (pop_req)
    );

    // back end: result formatting and output register
    fhd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req_valid        (pop_valid),
        .req_ready        (pop_ready),
        .req              (pop_req),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_opcode         (m_opcode),
        .m_frame_flags    (m_frame_flags),
        .m_req_id         (m_req_id),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_has_byte       (m_has_byte),
        .m_frame_first    (m_frame_first),
        .m_frame_last     (m_frame_last)
    );

endmodule

// ===== tb/frame_header_deframer_tb.sv =====
// frame_header_deframer_tb: self-checking testbench for the frame header deframer.
// Depends on fhd_pkg and frame_header_deframer; predicts every result in-line
// and compares it in arrival order while both sides idle and stall at random.
module frame_header_deframer_tb;

    localparam int RESET_CYCLES    = 4;
    localparam int DRAIN_CYCLES    = 8;     // FIFO and output register, with margin
    localparam int WATCHDOG_CYCLES = 5000;  // cycles with no handshake on either side
    localparam int HOLD_CYCLES     = 150;   // receiver hold-off in the fill test
    localparam int MAX_REPORTS     = 10;
    localparam logic [1:0] CFG_UNUSED = 2'd3;  // no register behind this index

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  opcode;
        logic [15:0] flags;
        logic [31:0] req_id;
        logic [31:0] length;
        logic [7:0]  data;
        logic        has_byte;
        logic        first;
        logic        last;
    } frame_result_t;

    // shapes of stimulus the random traffic is built from
    typedef enum int {
        PLAN_GOOD,
        PLAN_EMPTY,
        PLAN_BAD_MAGIC,
        PLAN_BAD_VERSION,
        PLAN_BAD_LENGTH,
        PLAN_TRUNCATED,
        PLAN_PARTIAL,
        PLAN_NOISE
    } frame_plan_t;

    // ---------------------------------------------------------------- DUT I/O
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_addr      = fhd_pkg::CFG_MAX_LEN;
    logic [31:0] cfg_wr_data   = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_operation   = fhd_pkg::OP_BYTE;
    logic [7:0]  s_stream_byte = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_opcode;
    logic [15:0] m_frame_flags;
    logic [31:0] m_req_id;
    logic [31:0] m_payload_length;
    logic [7:0]  m_payload_byte;
    logic        m_has_byte;
    logic        m_frame_first;
    logic        m_frame_last;

    frame_header_deframer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_stream_byte   (s_stream_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_opcode        (m_opcode),
        .m_frame_flags   (m_frame_flags),
        .m_req_id        (m_req_id),
        .m_payload_length(m_payload_length),
        .m_payload_byte  (m_payload_byte),
        .m_has_byte      (m_has_byte),
        .m_frame_first   (m_frame_first),
        .m_frame_last    (m_frame_last)
    );

    // ------------------------------------------------------- predictor state
    logic [7:0]    hdr_shadow [0:fhd_pkg::HDR_BYTES-1];
    logic [4:0]    hdr_fill    = '0;
    logic [31:0]   bytes_left  = '0;
    bit            frame_open  = 1'b0;
    bit            link_halted = 1'b0;
    fhd_pkg::cfg_t regs_shadow;

    frame_result_t pending_results [$];

    int send_idle_pct  = 0;   // chance in 100 that the sender idles before a request
    int recv_stall_pct = 0;   // chance in 100 that m_ready is low in a cycle
    bit hold_m_ready   = 1'b0;

    int items_sent      = 0;
    int results_checked = 0;
    int payload_results = 0;
    int empty_results   = 0;
    int error_results   = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    // ------------------------------------------------------------ clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // big-endian word from the shadow header
    function automatic logic [31:0] hdr_word(input int at);
        return {hdr_shadow[at], hdr_shadow[at+1], hdr_shadow[at+2], hdr_shadow[at+3]};
    endfunction

    // header fields as every good-frame result carries them
    function automatic frame_result_t header_fields();
        frame_result_t r;
        r        = '0;
        r.status = fhd_pkg::STATUS_OK;
        r.opcode = hdr_shadow[5];
        r.flags  = {hdr_shadow[6], hdr_shadow[7]};
        r.req_id = hdr_word(8);
        r.length = hdr_word(12);
        return r;
    endfunction

    // appends one prediction behind the outstanding ones
    function automatic void expect_result(input frame_result_t r);
        pending_results = {pending_results, r};
    endfunction

    // Advances the deframer's expected state by one accepted request and
    // queues the result it must produce, if any.
    function automatic void deframe_request(input logic op, input logic [7:0] b);
        frame_result_t r;
        logic [31:0]   len;
        r = '0;
        if (op == fhd_pkg::OP_CLEAR) begin
            // clear drops everything in flight, keeps the registers
            hdr_fill    = '0;
            bytes_left  = '0;
            frame_open  = 1'b0;
            link_halted = 1'b0;
        end else if (link_halted) begin
            // halted: every byte answers with the length status, all else zero
            r.status = fhd_pkg::STATUS_BAD_LENGTH;
            expect_result(r);
        end else if (frame_open) begin
            r          = header_fields();
            len        = r.length;
            r.data     = b;
            r.has_byte = 1'b1;
            r.first    = (bytes_left == len);
            r.last     = (bytes_left == 32'd1);
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 32'd0) begin
                frame_open = 1'b0;
                hdr_fill   = '0;
            end
            expect_result(r);
        end else begin
            hdr_shadow[hdr_fill[3:0]] = b;
            hdr_fill = hdr_fill + 5'd1;
            if (hdr_fill == fhd_pkg::HDR_BYTES) begin
                // full header: magic, then version, then length limit
                hdr_fill = '0;
                len      = hdr_word(12);
                if (hdr_word(0) != regs_shadow.magic) begin
                    r.status    = fhd_pkg::STATUS_BAD_MAGIC;
                    link_halted = 1'b1;
                    expect_result(r);
                end else if (hdr_shadow[4] != regs_shadow.version) begin
                    r.status    = fhd_pkg::STATUS_BAD_VERSION;
                    link_halted = 1'b1;
                    expect_result(r);
                end else if (len > regs_shadow.max_len) begin
                    r.status    = fhd_pkg::STATUS_BAD_LENGTH;
                    link_halted = 1'b1;
                    expect_result(r);
                end else if (len == 32'd0) begin
                    // empty frame: one byteless result that is first and last
                    r       = header_fields();
                    r.first = 1'b1;
                    r.last  = 1'b1;
                    expect_result(r);
                end else begin
                    frame_open = 1'b1;
                    bytes_left = len;
                end
            end
        end
    endfunction

    function automatic string describe(input frame_result_t r);
        return $sformatf({"status=%0d opcode=%02h flags=%04h id=%08h len=%08h ",
                          "byte=%02h has_byte=%0b first=%0b last=%0b"},
                         r.status, r.opcode, r.flags, r.req_id, r.length,
                         r.data, r.has_byte, r.first, r.last);
    endfunction

    // ------------------------------------------------------- request driver
    // Called at a rising edge; returns at the edge that accepted the request.
    // Valid is left high so back-to-back requests need no extra assignment.
    task automatic send_request(input logic op, input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_stream_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_request(op, b);
        items_sent++;
    endtask

    // bytes lo..hi of a 16-byte header, most significant first
    task automatic send_header_bytes(input logic [127:0] hdr, input int lo, input int hi);
        for (int i = lo; i <= hi; i++)
            send_request(fhd_pkg::OP_BYTE, hdr[127 - 8*i -: 8]);
    endtask

    task automatic send_random_bytes(input int n);
        repeat (n) send_request(fhd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // Idle point: nothing pending, then enough cycles for requests that
    // return nothing (partial headers, clears) to leave the pipeline.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers; the version write carries junk above bit 7.
    task automatic program_regs(input logic [31:0] max_len, input logic [31:0] magic,
                                input logic [7:0] version, input bit poke_unused);
        logic [31:0] word;
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= fhd_pkg::CFG_MAX_LEN;
        cfg_wr_data <= max_len;
        @(posedge aclk);
        regs_shadow.max_len = max_len;
        cfg_addr    <= fhd_pkg::CFG_MAGIC;
        cfg_wr_data <= magic;
        @(posedge aclk);
        regs_shadow.magic = magic;
        word        = $urandom;
        word[7:0]   = version;
        cfg_addr    <= fhd_pkg::CFG_VERSION;
        cfg_wr_data <= word;
        @(posedge aclk);
        regs_shadow.version = version;
        if (poke_unused) begin
            // must be dropped by the block
            cfg_addr    <= CFG_UNUSED;
            cfg_wr_data <= $urandom;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed frames with random content; the rest are broken
    // frames, partial headers and loose noise.
    task automatic run_traffic(input int n_items);
        int          target;
        int          roll;
        int          tail;
        frame_plan_t plan;
        logic [31:0] magic;
        logic [31:0] len;
        logic [31:0] lim;
        logic [31:0] req_id;
        logic [15:0] flags;
        logic [7:0]  version;
        logic [7:0]  opcode;
        target = items_sent + n_items;
        while (items_sent < target) begin
            roll    = $urandom_range(0, 99);
            magic   = regs_shadow.magic;
            version = regs_shadow.version;
            opcode  = 8'($urandom);
            flags   = 16'($urandom);
            req_id  = $urandom;
            // short payloads keep the run fast, an occasional longer one
            lim = (regs_shadow.max_len < 12) ? regs_shadow.max_len : 32'd12;
            if ($urandom_range(0, 9) == 0 && regs_shadow.max_len >= 40)
                lim = 40;
            len = (lim == 0) ? 32'd0 : 32'($urandom_range(1, lim));

            if (roll < 45)      plan = PLAN_GOOD;
            else if (roll < 53) plan = PLAN_EMPTY;
            else if (roll < 60) plan = PLAN_BAD_MAGIC;
            else if (roll < 66) plan = PLAN_BAD_VERSION;
            else if (roll < 73) plan = PLAN_BAD_LENGTH;
            else if (roll < 82) plan = PLAN_TRUNCATED;
            else if (roll < 92) plan = PLAN_PARTIAL;
            else                plan = PLAN_NOISE;

            case (plan)
                PLAN_EMPTY: begin
                    len = '0;
                end
                PLAN_BAD_MAGIC: begin
                    magic ^= 32'h1 << $urandom_range(0, 31);
                end
                PLAN_BAD_VERSION: begin
                    version ^= 8'h1 << $urandom_range(0, 7);
                end
                PLAN_BAD_LENGTH: begin
                    // with the limit at all ones no length can exceed it
                    if (regs_shadow.max_len == '1)
                        plan = PLAN_GOOD;
                    else if ($urandom_range(0, 1))
                        len = regs_shadow.max_len + 1;
                    else
                        len = regs_shadow.max_len + 1 + ($urandom % ~regs_shadow.max_len);
                end
                PLAN_TRUNCATED: begin
                    // declared payload cut short by a clear
                    if (regs_shadow.max_len == 0)
                        plan = PLAN_EMPTY;
                    else if ($urandom_range(0, 3) == 0)
                        len = regs_shadow.max_len;
                    else
                        len = 1 + ($urandom % regs_shadow.max_len);
                end
                default: ;
            endcase

            if (plan == PLAN_PARTIAL) begin
                send_random_bytes($urandom_range(1, fhd_pkg::HDR_BYTES - 1));
                send_request(fhd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
            end else if (plan == PLAN_NOISE) begin
                repeat ($urandom_range(1, 4))
                    send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else begin
                send_header_bytes({magic, version, opcode, flags, req_id, len}, 0, 15);
                case (plan)
                    PLAN_BAD_MAGIC, PLAN_BAD_VERSION, PLAN_BAD_LENGTH: begin
                        // a few bytes into the halt, then release it
                        send_random_bytes($urandom_range(0, 3));
                        send_request(fhd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
                    end
                    PLAN_TRUNCATED: begin
                        tail = $urandom_range(0, 3);
                        if (tail >= len)
                            tail = len - 1;
                        send_random_bytes(tail);
                        send_request(fhd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
                    end
                    default: begin
                        send_random_bytes(len);
                    end
                endcase
            end
        end
    endtask

    // one traffic phase: settle, reprogram, set the idle mix, run
    task automatic run_phase(input int idle, input int stall, input logic [31:0] max_len,
                             input logic [31:0] magic, input logic [7:0] version,
                             input int n_items);
        wait_drained();
        program_regs(max_len, magic, version, 1'b0);
        send_idle_pct  = idle;
        recv_stall_pct <= stall;
        run_traffic(n_items);
    endtask

    // ------------------------------------------------------------- tests
    // Reset registers (magic 0, version 0): an all-ones header fails on the
    // magic, bytes while halted, clear, and a header cut off by a clear.
    task automatic test_corner_bytes();
        send_request(fhd_pkg::OP_CLEAR, 8'hFF);
        send_header_bytes({32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF}, 0, 15);
        send_request(fhd_pkg::OP_BYTE, 8'h00);
        send_request(fhd_pkg::OP_BYTE, 8'hFF);
        send_request(fhd_pkg::OP_CLEAR, 8'h00);
        send_request(fhd_pkg::OP_BYTE, 8'h00);
        send_request(fhd_pkg::OP_BYTE, 8'h5A);
        send_request(fhd_pkg::OP_BYTE, 8'hFF);
        send_request(fhd_pkg::OP_CLEAR, 8'h5A);
    endtask

    // Registers rewritten halfway through a header must be the ones used at
    // the check; the write to the unused index must change nothing.
    task automatic test_config_mid_header();
        logic [127:0] hdr;
        hdr = {32'h5AA5_0FF0, 8'h80, 8'h3C, 16'h8001, 32'h0000_0001, 32'd2};
        wait_drained();
        program_regs(32'd0, 32'd0, 8'd0, 1'b0);
        send_header_bytes(hdr, 0, 8);
        wait_drained();
        program_regs(32'd2, 32'h5AA5_0FF0, 8'h80, 1'b1);
        send_header_bytes(hdr, 9, 15);
        send_random_bytes(2);
    endtask

    task automatic test_back_to_back();
        run_phase(0, 0, fhd_pkg::MAX_LEN_RESET, 32'h1234_5678, 8'h01, 250);
    endtask

    // zero limit: every non-empty header is a length error
    task automatic test_sender_gaps();
        run_phase(85, 0, 32'd0, 32'hFFFF_FFFF, 8'hFF, 250);
    endtask

    // all-ones limit: huge declared lengths, cut short by clears
    task automatic test_receiver_stalls();
        run_phase(0, 85, 32'hFFFF_FFFF, 32'd0, 8'd0, 250);
    endtask

    task automatic test_mixed_idle();
        run_phase(29, 29, 32'd5, $urandom, 8'($urandom), 250);
    endtask

    // Receiver holds off while a long frame streams in, so the queue and
    // output register fill and s_ready must drop until the hold ends.
    task automatic test_backpressure_fill();
        run_phase(0, 0, fhd_pkg::MAX_LEN_RESET, 32'hDEAD_0001, 8'h07, 0);
        // start from a clean header whatever the last phase left behind
        send_request(fhd_pkg::OP_CLEAR, 8'h00);
        fork
            begin
                hold_m_ready <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_m_ready <= 1'b0;
            end
        join_none
        send_header_bytes({32'hDEAD_0001, 8'h07, 8'hA0, 16'h0F0F, 32'h8000_0000, 32'd40},
                          0, 15);
        send_random_bytes(40);
    endtask

    // ------------------------------------------------------------- main
    initial begin
        regs_shadow.max_len = fhd_pkg::MAX_LEN_RESET;
        regs_shadow.magic   = fhd_pkg::MAGIC_RESET;
        regs_shadow.version = fhd_pkg::VERSION_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_corner_bytes();
        test_config_mid_header();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idle();
        test_backpressure_fill();

        wait_drained();
        $display("summary: %0d requests, %0d results checked (%0d payload bytes,",
                 items_sent, results_checked, payload_results);
        $display("  %0d empty frames, %0d error or halted), %0d mismatches",
                 empty_results, error_results, mismatches);
        $display({"summary: reset and rewritten registers, limits 0/5/64K/all-ones, ",
                  "idle and stall mixes, full back-pressure hold"});
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[frame_header_deframer] OK");
        end else begin
            $display("[frame_header_deframer] ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------ receiver
    always @(posedge aclk) begin
        if (!aresetn || hold_m_ready)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------- result checker
    // Results leave in request order, so each one is matched to the oldest
    // outstanding prediction.
    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_opcode, m_frame_flags, m_req_id, m_payload_length,
                   m_payload_byte, m_has_byte, m_frame_first, m_frame_last};
            results_checked++;
            if (got.has_byte)
                payload_results++;
            else if (got.status == fhd_pkg::STATUS_OK)
                empty_results++;
            else
                error_results++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d with nothing outstanding: %s",
                             results_checked, describe(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d mismatch", results_checked);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // -------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("no request or result moved for %0d cycles, %0d outstanding",
                         idle_cycles, pending_results.size());
                $display("[frame_header_deframer] ERROR");
                $finish;
            end
        end
    end

endmodule
